### rtl/core/otrc_pkg.sv
// Shared types and constants for the overcurrent trip run controller.
// Used by otrc_cfg, otrc_core and the top level; depends on nothing.
`default_nettype none

package otrc_pkg;

  localparam int OpcodeW  = 3;
  localparam int CurrentW = 16;
  localparam int Limit1W  = 10;
  localparam int Limit2W  = 13;
  localparam int TimeW    = 20;
  localparam int PeakW    = 15;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;

  localparam logic [Limit1W-1:0] Limit1Reset   = 10'd80;
  localparam logic [Limit2W-1:0] Limit2Reset   = 13'd800;
  localparam logic [TimeW-1:0]   RunLimitReset = 20'd1000;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_STOP    = 2'd1,
    MODE_RUN     = 2'd2,
    MODE_TRIP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REASON_NONE = 2'd0,
    REASON_CH1  = 2'd1,
    REASON_CH2  = 2'd2
  } reason_t;

  typedef enum logic [OpcodeW-1:0] {
    OP_SAMPLE = 3'd0,
    OP_TICK   = 3'd1,
    OP_RUN    = 3'd2,
    OP_STOP   = 3'd3,
    OP_RESET  = 3'd4
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIP_LIMIT_1 = 2'd0,
    CFG_TRIP_LIMIT_2 = 2'd1,
    CFG_RUN_LIMIT    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [Limit1W-1:0] trip_limit_1;
    logic [Limit2W-1:0] trip_limit_2;
    logic [TimeW-1:0]   run_limit_ms;
  } limits_t;

  typedef struct packed {
    mode_t              mode;
    reason_t            trip;
    logic [PeakW-1:0]   peak_1;
    logic [PeakW-1:0]   peak_2;
    logic [TimeW-1:0]   elapsed;
  } ctrl_state_t;

endpackage

`default_nettype wire

### rtl/core/otrc_cfg.sv
// Configuration register bank: trip limits and run length.
// Depends on otrc_pkg.
`default_nettype none

module otrc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [otrc_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [otrc_pkg::CfgDataW-1:0]  wr_data,
  output otrc_pkg::limits_t                   limits
);
  import otrc_pkg::*;

  limits_t limits_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits_reg.trip_limit_1 <= Limit1Reset;
      limits_reg.trip_limit_2 <= Limit2Reset;
      limits_reg.run_limit_ms <= RunLimitReset;
    end else if (wr_en) begin
      // An index past the last register is dropped.
      case (cfg_index_t'(wr_index))
        CFG_TRIP_LIMIT_1: limits_reg.trip_limit_1 <= wr_data[Limit1W-1:0];
        CFG_TRIP_LIMIT_2: limits_reg.trip_limit_2 <= wr_data[Limit2W-1:0];
        CFG_RUN_LIMIT:    limits_reg.run_limit_ms <= wr_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign limits = limits_reg;

endmodule

`default_nettype wire

### rtl/core/otrc_core.sv
// Controller state and its update per item. The state register
// also serves as the result register. Depends on otrc_pkg.
`default_nettype none

module otrc_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic [otrc_pkg::OpcodeW-1:0]   opcode,
  input  wire logic [otrc_pkg::CurrentW-1:0]  current_1,
  input  wire logic [otrc_pkg::CurrentW-1:0]  current_2,
  input  otrc_pkg::limits_t                   limits,
  output otrc_pkg::ctrl_state_t               state
);
  import otrc_pkg::*;

  ctrl_state_t state_reg;
  ctrl_state_t state_next;

  logic signed [CurrentW:0] cur_1_s;
  logic signed [CurrentW:0] cur_2_s;
  logic signed [CurrentW:0] lim_1_s;
  logic signed [CurrentW:0] lim_2_s;
  logic signed [CurrentW:0] pk_1_s;
  logic signed [CurrentW:0] pk_2_s;

  always_comb begin
    cur_1_s = signed'({current_1[CurrentW-1], current_1});
    cur_2_s = signed'({current_2[CurrentW-1], current_2});
    lim_1_s = signed'({{(CurrentW + 1 - Limit1W){1'b0}}, limits.trip_limit_1});
    lim_2_s = signed'({{(CurrentW + 1 - Limit2W){1'b0}}, limits.trip_limit_2});
    pk_1_s  = signed'({{(CurrentW + 1 - PeakW){1'b0}}, state_reg.peak_1});
    pk_2_s  = signed'({{(CurrentW + 1 - PeakW){1'b0}}, state_reg.peak_2});

    state_next = state_reg;
    case (opcode_t'(opcode))
      OP_SAMPLE: begin
        if (state_reg.mode == MODE_RUN) begin
          // A larger current is positive, so its low bits are the new peak.
          if (cur_1_s > pk_1_s) state_next.peak_1 = current_1[PeakW-1:0];
          if (cur_2_s > pk_2_s) state_next.peak_2 = current_2[PeakW-1:0];
          if (cur_1_s > lim_1_s) begin
            state_next.trip = REASON_CH1;
            state_next.mode = MODE_TRIP;
          end else if (cur_2_s > lim_2_s) begin
            state_next.trip = REASON_CH2;
            state_next.mode = MODE_TRIP;
          end
        end
      end
      OP_TICK: begin
        if (state_reg.mode == MODE_RUN) begin
          if (state_reg.elapsed < limits.run_limit_ms) begin
            state_next.elapsed = state_reg.elapsed + TimeW'(1);
          end else begin
            state_next.mode = MODE_STOP;
          end
        end
      end
      OP_RUN: begin
        if (state_reg.trip == REASON_NONE &&
            (state_reg.mode == MODE_STANDBY || state_reg.mode == MODE_STOP)) begin
          state_next.elapsed = '0;
          state_next.peak_1  = '0;
          state_next.peak_2  = '0;
          state_next.mode    = MODE_RUN;
        end
      end
      OP_STOP: begin
        // The trip reason stays, so a later run is still refused.
        state_next.mode = MODE_STOP;
      end
      OP_RESET: begin
        if (state_reg.trip != REASON_NONE) begin
          state_next.trip    = REASON_NONE;
          state_next.mode    = MODE_STANDBY;
          state_next.elapsed = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_reg.mode    <= MODE_STANDBY;
      state_reg.trip    <= REASON_NONE;
      state_reg.peak_1  <= '0;
      state_reg.peak_2  <= '0;
      state_reg.elapsed <= '0;
    end else if (step) begin
      state_reg <= state_next;
    end
  end

  assign state = state_reg;

endmodule

`default_nettype wire

### rtl/core/overcurrent_trip_run_controller.sv
// Overcurrent trip run controller, top level.
// Depends on otrc_pkg, otrc_cfg and otrc_core.
//
// Each input item is one opcode (sample, tick, run, stop, reset) with two
// signed currents that matter only for a sample. Every item yields exactly
// one result item: mode, trip reason, generator enable, both peaks and the
// elapsed run time, all as they stand after the item.
// Channels use valid/ready. An accepted item lands in an input register;
// the controller state is updated from it once the result register is free;
// the state register itself is the result register. One item per cycle is
// sustained while the receiver keeps up, as the update is a single
// compare-and-select pass.
// When the receiver stalls, the result holds; one more item waits in the
// input register, and in_ready drops only while both are occupied.
// Configuration writes go to cfg_index/cfg_data and are always taken
// (cfg_ready is high); indexes past the last register are ignored.
// Synchronous reset returns to standby with no trip, zero peaks and time,
// default limits, and empty input and output stages.
`default_nettype none

module overcurrent_trip_run_controller (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output wire logic                           in_ready,
  input  wire logic [otrc_pkg::OpcodeW-1:0]   opcode,
  input  wire logic [otrc_pkg::CurrentW-1:0]  current_1,
  input  wire logic [otrc_pkg::CurrentW-1:0]  current_2,
  output wire logic                           out_valid,
  input  wire logic                           out_ready,
  output wire logic [1:0]                     mode_now,
  output wire logic [1:0]                     trip_reason,
  output wire logic                           gen_enable,
  output wire logic [otrc_pkg::PeakW-1:0]     peak_current_1,
  output wire logic [otrc_pkg::PeakW-1:0]     peak_current_2,
  output wire logic [otrc_pkg::TimeW-1:0]     run_time_ms,
  input  wire logic                           cfg_valid,
  output wire logic                           cfg_ready,
  input  wire logic [otrc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [otrc_pkg::CfgDataW-1:0]  cfg_data
);
  import otrc_pkg::*;

  logic                in_full;
  logic [OpcodeW-1:0]  op_q;
  logic [CurrentW-1:0] cur_1_q;
  logic [CurrentW-1:0] cur_2_q;
  logic                res_valid;
  logic                advance;
  logic                take;
  limits_t             limits;
  ctrl_state_t         state;

  assign advance   = in_full && (!res_valid || out_ready);
  assign take      = in_valid && in_ready;
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_q    <= opcode;
      cur_1_q <= current_1;
      cur_2_q <= current_2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  otrc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  otrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .opcode    (op_q),
    .current_1 (cur_1_q),
    .current_2 (cur_2_q),
    .limits    (limits),
    .state     (state)
  );

  assign out_valid      = res_valid;
  assign mode_now       = state.mode;
  assign trip_reason    = state.trip;
  assign gen_enable     = (state.mode == MODE_RUN);
  assign peak_current_1 = state.peak_1;
  assign peak_current_2 = state.peak_2;
  assign run_time_ms    = state.elapsed;

endmodule

`default_nettype wire
